[rtl/ecsb_pkg.sv]
// Package for the Ethernet controller CSR block: item types, register offsets,
// command codes, PHY reset values and the EEPROM checksum function.
// No dependencies.
package ecsb_pkg;

   localparam int REG_WINDOW_BYTES_DEF = 64;
   localparam int PHY_REG_COUNT        = 32;
   localparam int PHY_IDX_W            = $clog2(PHY_REG_COUNT);
   localparam int ACCESS_MAX_BYTES     = 8;

   localparam int OFS_STATUS  = 1;
   localparam int OFS_COMMAND = 2;
   localparam int OFS_POINTER = 4;
   localparam int OFS_PORT    = 8;
   localparam int OFS_EEPROM  = 14;
   localparam int OFS_MDI     = 16;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] DMA_NONE    = 2'd0;
   localparam logic [1:0] DMA_OR_WORD = 2'd1;
   localparam logic [1:0] DMA_DUMP    = 2'd2;

   localparam logic [1:0] PORT_RESET     = 2'd0;
   localparam logic [1:0] PORT_DUMP      = 2'd1;
   localparam logic [1:0] PORT_SEL_RESET = 2'd2;
   localparam logic [1:0] PORT_NOP       = 2'd3;

   localparam logic [3:0] CU_CMD_COMPLETE  = 4'h1;
   localparam logic [3:0] CU_CMD_LOAD_BASE = 4'h6;
   localparam logic [3:0] RU_CMD_LOAD_BASE = 4'h6;

   localparam logic [7:0]  STAT_MDI_DONE = 8'h08;
   localparam logic [7:0]  STAT_CU_DONE  = 8'ha0;
   localparam logic [15:0] DMA_OR_VALUE  = 16'ha000;

   localparam logic [1:0] MDI_OP_WRITE  = 2'd1;
   localparam logic [1:0] MDI_OP_READ   = 2'd2;
   localparam logic [4:0] MDI_PHY_ADDR  = 5'd1;
   localparam logic [PHY_IDX_W-1:0] PHY_CTRL_REG = '0;

   localparam logic [2:0]  EE_OP_READ     = 3'b110;
   localparam logic [3:0]  EE_FRAME_BITS  = 4'd10;
   localparam logic [4:0]  EE_WORD_BITS   = 5'd16;
   localparam logic [5:0]  EE_IDX_W0      = 6'd0;
   localparam logic [5:0]  EE_IDX_W1      = 6'd1;
   localparam logic [5:0]  EE_IDX_W2      = 6'd2;
   localparam logic [5:0]  EE_IDX_W3      = 6'd3;
   localparam logic [5:0]  EE_IDX_CSUM    = 6'd63;
   localparam logic [15:0] EE_WORD3       = 16'h0003;
   localparam logic [15:0] EE_SUM_TARGET  = 16'hbaba;
   localparam logic [47:0] STATION_RESET  = 48'd1275907298386;

   localparam logic [15:0] PHY_RESET [PHY_REG_COUNT] = '{
      0: 16'h3000, 1: 16'h782d, 2: 16'h02a8, 3: 16'h0150,
      4: 16'h01e1, 5: 16'h41e1, 6: 16'h0001, default: 16'h0000};

   typedef struct packed {
      logic        cmd;
      logic [7:0]  offset;
      logic [3:0]  access_size;
      logic [63:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic [1:0]  dma_op;
      logic [31:0] dma_addr;
   } rsp_item_type;

   typedef struct packed {
      logic       drive;
      logic       clear;
      logic [7:0] pins;
   } ee_ctl_type;

   typedef struct packed {
      logic [7:0] pins;
      logic       dout;
   } ee_stat_type;

   typedef struct packed {
      logic        frame;
      logic        clear;
      logic [31:0] frame_word;
   } mdi_ctl_type;

   function automatic logic [15:0] ee_checksum(input logic [47:0] station);
      logic [15:0] sum;
      sum = station[15:0] + station[31:16] + station[47:32] + EE_WORD3;
      return EE_SUM_TARGET - sum;
   endfunction

endpackage

[rtl/ecsb_eeprom.sv]
// Bit-banged serial EEPROM reader with the station address and checksum words.
// Depends on ecsb_pkg.
module ecsb_eeprom (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [47:0]          csr_wr_data,
   input  ecsb_pkg::ee_ctl_type ctl,
   output ecsb_pkg::ee_stat_type stat
);
   import ecsb_pkg::*;

   logic [47:0] station_ff, station_in;
   logic [15:0] csum_ff, csum_in;
   logic [9:0]  shift_ff, shift_in;
   logic [3:0]  in_cnt_ff, in_cnt_in;
   logic [4:0]  out_cnt_ff, out_cnt_in;
   logic        just_ff, just_in;
   logic [15:0] out_word_ff, out_word_in;
   logic [7:0]  pins_ff, pins_in;

   logic [9:0]  sh_next;
   logic [3:0]  cnt_next;
   logic [15:0] word_sel;

   assign sh_next  = {shift_ff[8:0], ctl.pins[2]};
   assign cnt_next = in_cnt_ff + 4'd1;

   always_comb begin
      unique case (sh_next[5:0])
         EE_IDX_W0:   word_sel = station_ff[15:0];
         EE_IDX_W1:   word_sel = station_ff[31:16];
         EE_IDX_W2:   word_sel = station_ff[47:32];
         EE_IDX_W3:   word_sel = EE_WORD3;
         EE_IDX_CSUM: word_sel = csum_ff;
         default:     word_sel = 16'h0000;
      endcase
   end

   assign station_in = csr_wr_en ? csr_wr_data : station_ff;
   assign csum_in    = csr_wr_en ? ee_checksum(csr_wr_data) : csum_ff;

   always_comb begin
      shift_in    = shift_ff;
      in_cnt_in   = in_cnt_ff;
      out_cnt_in  = out_cnt_ff;
      just_in     = just_ff;
      out_word_in = out_word_ff;
      pins_in     = pins_ff;
      if (ctl.clear) begin
         shift_in    = '0;
         in_cnt_in   = '0;
         out_cnt_in  = '0;
         just_in     = 1'b0;
         out_word_in = '0;
         pins_in     = '0;
      end else if (ctl.drive) begin
         pins_in = ctl.pins;
         if (!ctl.pins[1]) begin
            shift_in   = '0;
            in_cnt_in  = '0;
            out_cnt_in = '0;
            just_in    = 1'b0;
         end else if (!pins_ff[0] && ctl.pins[0]) begin
            if (out_cnt_ff == '0) begin
               if (cnt_next == EE_FRAME_BITS) begin
                  if (sh_next[8:6] == EE_OP_READ) begin
                     out_word_in = word_sel;
                     out_cnt_in  = EE_WORD_BITS;
                     just_in     = 1'b1;
                  end
                  in_cnt_in = '0;
                  shift_in  = '0;
               end else begin
                  in_cnt_in = cnt_next;
                  shift_in  = sh_next;
               end
            end
         end else if (pins_ff[0] && !ctl.pins[0] && out_cnt_ff != '0) begin
            if (just_ff) begin
               just_in = 1'b0;
            end else begin
               out_word_in = {out_word_ff[14:0], 1'b0};
               out_cnt_in  = out_cnt_ff - 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff  <= STATION_RESET;
         csum_ff     <= ee_checksum(STATION_RESET);
         shift_ff    <= '0;
         in_cnt_ff   <= '0;
         out_cnt_ff  <= '0;
         just_ff     <= 1'b0;
         out_word_ff <= '0;
         pins_ff     <= '0;
      end else begin
         station_ff  <= station_in;
         csum_ff     <= csum_in;
         shift_ff    <= shift_in;
         in_cnt_ff   <= in_cnt_in;
         out_cnt_ff  <= out_cnt_in;
         just_ff     <= just_in;
         out_word_ff <= out_word_in;
         pins_ff     <= pins_in;
      end
   end

   assign stat.pins = pins_ff;
   assign stat.dout = (out_cnt_ff != '0) && out_word_ff[15];

`ifndef SYNTHESIS
   a_in_cnt_range: assert property (@(posedge clock) disable iff (reset)
      in_cnt_ff < EE_FRAME_BITS) else $error("eeprom input count out of range");
   a_out_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= EE_WORD_BITS) else $error("eeprom output count out of range");
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> (in_cnt_ff == '0) && (out_cnt_ff == '0) && (pins_ff == '0))
      else $error("eeprom reader not idle after clear");
`endif

endmodule

[rtl/ecsb_mdi.sv]
// MDI port: PHY register file and the MDI control word.
// Depends on ecsb_pkg.
module ecsb_mdi (
   input  logic                  clock,
   input  logic                  reset,
   input  ecsb_pkg::mdi_ctl_type ctl,
   output logic [31:0]           mdi_word
);
   import ecsb_pkg::*;

   logic [15:0] phy_ff [PHY_REG_COUNT];
   logic [31:0] mdi_word_ff, mdi_word_in;

   logic [1:0]           op;
   logic [4:0]           phy_addr;
   logic [PHY_IDX_W-1:0] ridx;
   logic [15:0]          data_wr;
   logic [15:0]          frame_data;
   logic                 phy_we;

   assign op       = ctl.frame_word[27:26];
   assign phy_addr = ctl.frame_word[25:21];
   assign ridx     = ctl.frame_word[16 +: PHY_IDX_W];
   assign data_wr  = ctl.frame_word[15:0];

   always_comb begin
      frame_data = 16'h0000;
      phy_we     = 1'b0;
      if (phy_addr == MDI_PHY_ADDR && op == MDI_OP_READ) begin
         frame_data = phy_ff[ridx];
      end else if (phy_addr == MDI_PHY_ADDR && op == MDI_OP_WRITE) begin
         frame_data = (ridx == PHY_CTRL_REG && data_wr[15]) ? phy_ff[PHY_CTRL_REG] : data_wr;
         phy_we     = 1'b1;
      end
   end

   always_comb begin
      mdi_word_in = mdi_word_ff;
      if (ctl.clear) begin
         mdi_word_in = '0;
      end else if (ctl.frame) begin
         mdi_word_in = {ctl.frame_word[31:29], 1'b1, ctl.frame_word[27:16], frame_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mdi_word_ff <= '0;
         for (int k = 0; k < PHY_REG_COUNT; k++) begin
            phy_ff[k] <= PHY_RESET[k];
         end
      end else begin
         mdi_word_ff <= mdi_word_in;
         if (ctl.frame && phy_we) begin
            phy_ff[ridx] <= frame_data;
         end
      end
   end

   assign mdi_word = mdi_word_ff;

endmodule

[rtl/ethernet_controller_csr_block_core.sv]
// Top level of the Ethernet controller CSR block: input stage, byte register
// file, command decode and result register. Depends on ecsb_pkg, ecsb_eeprom, ecsb_mdi.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_item  (ecsb_pkg::req_item_type)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_item  (ecsb_pkg::rsp_item_type)
//   csr     | in        | csr_wr_en              | csr_wr_data (station address)
//
// One item per cycle sustained while rsp_ready is high. An accepted item is held in the
// input register; the decode between it and the result register forms the result, and
// rsp_valid rises once that result is registered.
// Reset is synchronous; all state but s1_item_ff and rsp_item_ff takes its reset value.
// With rsp_ready low the result holds and one more item waits in the input register;
// req_ready then drops until the result is taken.
module ethernet_controller_csr_block_core #(
   parameter int REG_WINDOW_BYTES = ecsb_pkg::REG_WINDOW_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ecsb_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ecsb_pkg::rsp_item_type rsp_item,
   input  logic                   csr_wr_en,
   input  logic [47:0]            csr_wr_data
);
   import ecsb_pkg::*;

   localparam int         IDX_W = $clog2(REG_WINDOW_BYTES);
   localparam logic [8:0] WIN   = 9'(REG_WINDOW_BYTES);

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic [7:0]  bytes_ff [REG_WINDOW_BYTES];
   logic [7:0]  bytes_in [REG_WINDOW_BYTES];
   logic [31:0] gp_ff, gp_in;
   logic [31:0] cu_base_ff, cu_base_in;
   logic [31:0] ru_base_ff, ru_base_in;

   logic [7:0]  view  [REG_WINDOW_BYTES];
   logic [7:0]  wr    [REG_WINDOW_BYTES];

   logic        rsp_room, advance;
   logic        is_wr, oob, rd_go, wr_go;
   logic [3:0]  size;
   logic [8:0]  off9, acc_end;
   logic        rd_ee, rd_mdi;
   logic        hit_gp, hit_ee, hit_mdi, hit_port, hit_cmd;
   logic [63:0] rd_data;
   logic [31:0] gp_new, port_word;
   logic        port_clear, port_dump, cu_complete;
   logic [3:0]  cu_nib, ru_nib;
   logic [1:0]  dma_op;
   logic [31:0] dma_addr;

   ee_ctl_type  ee_ctl;
   ee_stat_type ee_stat;
   mdi_ctl_type mdi_ctl;
   logic [31:0] mdi_word;

   assign rsp_room  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && rsp_room;
   assign req_ready = !s1_valid_ff || rsp_room;

   assign s1_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign s1_item_in   = (req_valid && req_ready) ? req_item : s1_item_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign size    = s1_item_ff.access_size[3] ? 4'(ACCESS_MAX_BYTES) : s1_item_ff.access_size;
   assign off9    = {1'b0, s1_item_ff.offset};
   assign acc_end = off9 + {5'b0, size};
   assign oob     = acc_end > WIN;
   assign is_wr   = s1_item_ff.cmd == CMD_WRITE;
   assign rd_go   = !is_wr && !oob;
   assign wr_go   = is_wr && !oob;

   assign rd_ee    = rd_go && off9 <= 9'(OFS_EEPROM) && acc_end > 9'(OFS_EEPROM);
   assign rd_mdi   = rd_go && off9 <= 9'(OFS_MDI + 3) && acc_end > 9'(OFS_MDI);
   assign hit_gp   = wr_go && off9 <= 9'(OFS_POINTER + 3) && acc_end > 9'(OFS_POINTER);
   assign hit_ee   = wr_go && off9 <= 9'(OFS_EEPROM) && acc_end > 9'(OFS_EEPROM);
   assign hit_mdi  = wr_go && off9 <= 9'(OFS_MDI + 3) && acc_end >= 9'(OFS_MDI + 4);
   assign hit_port = wr_go && off9 <= 9'(OFS_PORT + 3) && acc_end >= 9'(OFS_PORT + 4);
   assign hit_cmd  = wr_go && off9 <= 9'(OFS_COMMAND + 1) && acc_end > 9'(OFS_COMMAND);

   always_comb begin
      view = bytes_ff;
      if (rd_ee) begin
         view[OFS_EEPROM]     = {ee_stat.pins[7:4], ee_stat.dout, ee_stat.pins[2:0]};
         view[OFS_EEPROM + 1] = 8'h00;
      end
      if (rd_mdi) begin
         for (int k = 0; k < 4; k++) begin
            view[OFS_MDI + k] = mdi_word[8*k +: 8];
         end
      end
   end

   always_comb begin
      logic [8:0] lane_idx;
      rd_data = '0;
      for (int i = 0; i < ACCESS_MAX_BYTES; i++) begin
         lane_idx = off9 + 9'(i);
         if (4'(i) < size && lane_idx < WIN) begin
            rd_data[8*i +: 8] = view[lane_idx[IDX_W-1:0]];
         end
      end
   end

   always_comb begin
      logic [8:0] lane_ofs;
      wr = view;
      for (int j = 0; j < REG_WINDOW_BYTES; j++) begin
         lane_ofs = 9'(j) - off9;
         if (wr_go && 9'(j) >= off9 && lane_ofs < {5'b0, size}) begin
            wr[j] = s1_item_ff.write_data[{lane_ofs[2:0], 3'b000} +: 8];
         end
      end
   end

   assign gp_new = hit_gp ? {wr[OFS_POINTER + 3], wr[OFS_POINTER + 2],
                             wr[OFS_POINTER + 1], wr[OFS_POINTER]} : gp_ff;
   assign port_word = {wr[OFS_PORT + 3], wr[OFS_PORT + 2], wr[OFS_PORT + 1], wr[OFS_PORT]};

   always_comb begin
      port_clear = 1'b0;
      port_dump  = 1'b0;
      unique case (port_word[1:0])
         PORT_RESET:     port_clear = hit_port;
         PORT_SEL_RESET: port_clear = hit_port;
         PORT_DUMP:      port_dump  = hit_port;
         PORT_NOP:       port_dump  = 1'b0;
         default:        port_dump  = 1'b0;
      endcase
   end

   assign cu_nib      = wr[OFS_COMMAND][7:4];
   assign ru_nib      = wr[OFS_COMMAND][3:0];
   assign cu_complete = hit_cmd && cu_nib == CU_CMD_COMPLETE;

   always_comb begin
      bytes_in = wr;
      if (hit_mdi) begin
         bytes_in[OFS_STATUS] = wr[OFS_STATUS] | STAT_MDI_DONE;
      end
      if (cu_complete) begin
         bytes_in[OFS_STATUS] = wr[OFS_STATUS] | STAT_CU_DONE;
      end
      if (hit_cmd) begin
         bytes_in[OFS_COMMAND] = 8'h00;
      end
      if (port_clear) begin
         for (int j = 0; j < REG_WINDOW_BYTES; j++) begin
            bytes_in[j] = 8'h00;
         end
      end
   end

   assign gp_in      = port_clear ? '0 : gp_new;
   assign cu_base_in = port_clear ? '0 :
                       (hit_cmd && cu_nib == CU_CMD_LOAD_BASE) ? gp_new : cu_base_ff;
   assign ru_base_in = port_clear ? '0 :
                       (hit_cmd && ru_nib == RU_CMD_LOAD_BASE) ? gp_new : ru_base_ff;

   always_comb begin
      dma_op   = DMA_NONE;
      dma_addr = '0;
      if (port_dump) begin
         dma_op   = DMA_DUMP;
         dma_addr = {port_word[31:2], 2'b00};
      end
      if (cu_complete) begin
         dma_op   = DMA_OR_WORD;
         dma_addr = cu_base_ff + gp_new;
      end
   end

   always_comb begin
      rsp_item_in = rsp_item_ff;
      if (advance) begin
         rsp_item_in.read_data = is_wr ? '0 : (oob ? '1 : rd_data);
         rsp_item_in.dma_op    = dma_op;
         rsp_item_in.dma_addr  = dma_addr;
      end
   end

   assign ee_ctl.drive = advance && hit_ee;
   assign ee_ctl.clear = advance && port_clear;
   assign ee_ctl.pins  = wr[OFS_EEPROM];

   assign mdi_ctl.frame      = advance && hit_mdi;
   assign mdi_ctl.clear      = advance && port_clear;
   assign mdi_ctl.frame_word = {wr[OFS_MDI + 3], wr[OFS_MDI + 2], wr[OFS_MDI + 1], wr[OFS_MDI]};

   ecsb_eeprom u_eeprom (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctl         (ee_ctl),
      .stat        (ee_stat)
   );

   ecsb_mdi u_mdi (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mdi_ctl),
      .mdi_word (mdi_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gp_ff        <= '0;
         cu_base_ff   <= '0;
         ru_base_ff   <= '0;
         for (int j = 0; j < REG_WINDOW_BYTES; j++) begin
            bytes_ff[j] <= 8'h00;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            gp_ff      <= gp_in;
            cu_base_ff <= cu_base_in;
            ru_base_ff <= ru_base_in;
            bytes_ff   <= bytes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready) else $error("input stalled with empty result register");
   a_no_dma_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.dma_op == DMA_NONE) |-> rsp_item_ff.dma_addr == '0)
      else $error("address given without a DMA request");
   a_clear_pointers: assert property (@(posedge clock) disable iff (reset)
      (advance && port_clear) |=> (gp_ff == '0) && (cu_base_ff == '0) && (mdi_word == '0))
      else $error("PORT reset left state behind");
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff) else $error("accepted item lost");
`endif

endmodule

[bench/tb.sv]
// Testbench for ethernet_controller_csr_block_core: directed and random register accesses,
// each result checked against an in-bench model of the CSR window, EEPROM and MDI port.
// Depends on ecsb_pkg and the RTL of the block.
module tb;
   import ecsb_pkg::*;

   localparam int WINDOW      = REG_WINDOW_BYTES_DEF;
   localparam int QUIET_LIMIT = 2000;
   localparam int PIN_CLK     = 0;
   localparam int PIN_CS      = 1;
   localparam int PIN_DI      = 2;
   localparam int PIN_DO      = 3;
   localparam logic [1:0] MDI_OP_INVALID = 2'd3;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_item_type req_item    = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en   = 1'b0;
   logic [47:0]  csr_wr_data = '0;

   logic [7:0]  csr_bytes [WINDOW];
   logic [31:0] gen_ptr, cu_base_q, ru_base_q, mdi_reg;
   logic [15:0] phy_file [PHY_REG_COUNT];
   logic [9:0]  ee_frame_q;
   logic [3:0]  ee_bits_in;
   logic [4:0]  ee_bits_out;
   logic        ee_primed;
   logic [15:0] ee_data_q;
   logic [7:0]  ee_pin_q;
   logic [47:0] station;

   rsp_item_type expected_rsp_q [$];
   int idle_pct       = 0;
   int stall_pct      = 0;
   int error_count    = 0;
   int quiet_cycles   = 0;
   int accepted_count = 0;

   ethernet_controller_csr_block_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] eeprom_word(input logic [5:0] idx);
      logic [15:0] sum;
      sum = station[15:0] + station[31:16] + station[47:32] + EE_WORD3;
      case (idx)
         EE_IDX_W0:   return station[15:0];
         EE_IDX_W1:   return station[31:16];
         EE_IDX_W2:   return station[47:32];
         EE_IDX_W3:   return EE_WORD3;
         EE_IDX_CSUM: return EE_SUM_TARGET - sum;
         default:     return '0;
      endcase
   endfunction

   function automatic logic [31:0] word32(input int at);
      return {csr_bytes[at+3], csr_bytes[at+2], csr_bytes[at+1], csr_bytes[at]};
   endfunction

   function automatic void clear_csr_state();
      foreach (csr_bytes[i]) csr_bytes[i] = '0;
      gen_ptr     = '0;
      cu_base_q   = '0;
      ru_base_q   = '0;
      mdi_reg     = '0;
      ee_frame_q  = '0;
      ee_bits_in  = '0;
      ee_bits_out = '0;
      ee_primed   = 1'b0;
      ee_data_q   = '0;
      ee_pin_q    = '0;
   endfunction

   function automatic void eeprom_drive(input logic [7:0] pins);
      if (!pins[PIN_CS]) begin
         ee_bits_in  = '0;
         ee_bits_out = '0;
         ee_primed   = 1'b0;
         ee_frame_q  = '0;
      end else if (!ee_pin_q[PIN_CLK] && pins[PIN_CLK]) begin
         if (ee_bits_out == '0) begin
            ee_frame_q = {ee_frame_q[8:0], pins[PIN_DI]};
            ee_bits_in = ee_bits_in + 4'd1;
            if (ee_bits_in == EE_FRAME_BITS) begin
               if (ee_frame_q[8:6] == EE_OP_READ) begin
                  ee_data_q   = eeprom_word(ee_frame_q[5:0]);
                  ee_bits_out = EE_WORD_BITS;
                  ee_primed   = 1'b1;
               end
               ee_bits_in = '0;
               ee_frame_q = '0;
            end
         end
      end else if (ee_pin_q[PIN_CLK] && !pins[PIN_CLK] && ee_bits_out != '0) begin
         if (ee_primed) begin
            ee_primed = 1'b0;
         end else begin
            ee_data_q   = ee_data_q << 1;
            ee_bits_out = ee_bits_out - 5'd1;
         end
      end
      ee_pin_q = pins;
   endfunction

   function automatic void mdi_exchange(input logic [31:0] v);
      logic [1:0]  op;
      logic [4:0]  phy;
      logic [4:0]  idx;
      logic [15:0] data;
      op   = v[27:26];
      phy  = v[25:21];
      idx  = v[20:16];
      data = v[15:0];
      if (phy == MDI_PHY_ADDR && op == MDI_OP_READ) begin
         data = phy_file[idx];
      end else if (phy == MDI_PHY_ADDR && op == MDI_OP_WRITE) begin
         if (idx == PHY_CTRL_REG && data[15])
            data = phy_file[PHY_CTRL_REG];
         phy_file[idx] = data;
      end else begin
         data = '0;
      end
      mdi_reg = {v[31:16], data} | (32'd1 << 28);
      csr_bytes[OFS_STATUS] |= STAT_MDI_DONE;
   endfunction

   function automatic rsp_item_type predict_access(input req_item_type item);
      rsp_item_type res;
      int           base;
      int           size;
      logic [31:0]  port;
      logic [7:0]   ee;
      logic [7:0]   lo;
      res  = '0;
      base = int'(item.offset);
      size = (item.access_size > 4'd8) ? ACCESS_MAX_BYTES : int'(item.access_size);
      if (base + size > WINDOW) begin
         if (item.cmd == CMD_READ)
            res.read_data = '1;
         return res;
      end
      if (item.cmd == CMD_READ) begin
         if (base <= OFS_EEPROM && base + size > OFS_EEPROM) begin
            ee = ee_pin_q;
            ee[PIN_DO] = (ee_bits_out != '0) && ee_data_q[15];
            csr_bytes[OFS_EEPROM]   = ee;
            csr_bytes[OFS_EEPROM+1] = '0;
         end
         if (base <= OFS_MDI + 3 && base + size > OFS_MDI)
            for (int i = 0; i < 4; i++) csr_bytes[OFS_MDI+i] = mdi_reg[8*i +: 8];
         for (int i = 0; i < size; i++) res.read_data[8*i +: 8] = csr_bytes[base+i];
         return res;
      end
      for (int i = 0; i < size; i++) csr_bytes[base+i] = item.write_data[8*i +: 8];
      if (base <= OFS_POINTER + 3 && base + size > OFS_POINTER)
         gen_ptr = word32(OFS_POINTER);
      if (base <= OFS_EEPROM && base + size > OFS_EEPROM)
         eeprom_drive(csr_bytes[OFS_EEPROM]);
      if (base <= OFS_MDI + 3 && base + size >= OFS_MDI + 4)
         mdi_exchange(word32(OFS_MDI));
      if (base <= OFS_PORT + 3 && base + size >= OFS_PORT + 4) begin
         port = word32(OFS_PORT);
         if (port[1:0] == PORT_RESET || port[1:0] == PORT_SEL_RESET) begin
            clear_csr_state();
         end else if (port[1:0] == PORT_DUMP) begin
            res.dma_op   = DMA_DUMP;
            res.dma_addr = {port[31:2], 2'b00};
         end
      end
      if (base <= OFS_COMMAND + 1 && base + size > OFS_COMMAND) begin
         lo = csr_bytes[OFS_COMMAND];
         if (lo[3:0] == RU_CMD_LOAD_BASE)
            ru_base_q = gen_ptr;
         if (lo[7:4] == CU_CMD_LOAD_BASE)
            cu_base_q = gen_ptr;
         if (lo[7:4] == CU_CMD_COMPLETE) begin
            res.dma_op   = DMA_OR_WORD;
            res.dma_addr = cu_base_q + gen_ptr;
            csr_bytes[OFS_STATUS] |= STAT_CU_DONE;
         end
         csr_bytes[OFS_COMMAND] = '0;
      end
      return res;
   endfunction

   function automatic logic [63:0] rand_data();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] pin_byte(input logic cs, input logic clk, input logic di);
      return {5'($urandom), di, cs, clk};
   endfunction

   task automatic send_access(input logic cmd, input logic [7:0] ofs, input logic [3:0] size,
                              input logic [63:0] data);
      req_item_type item;
      item.cmd         = cmd;
      item.offset      = ofs;
      item.access_size = size;
      item.write_data  = data;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(predict_access(item));
      accepted_count++;
   endtask

   task automatic load_station(input logic [47:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      station = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drive_pins(input logic [7:0] pins);
      case ($urandom_range(0, 3))
         0: send_access(CMD_WRITE, 8'(OFS_EEPROM - 2), 4'd4,
                        {$urandom, 8'($urandom), pins, 16'($urandom)});
         1: send_access(CMD_WRITE, 8'(OFS_EEPROM), 4'd2,
                        {$urandom, 16'($urandom), 8'($urandom), pins});
         default: send_access(CMD_WRITE, 8'(OFS_EEPROM), 4'd1, {$urandom, 24'($urandom), pins});
      endcase
   endtask

   task automatic read_pins();
      case ($urandom_range(0, 3))
         0: send_access(CMD_READ, 8'(OFS_EEPROM - 2), 4'd4, rand_data());
         1: send_access(CMD_READ, 8'(OFS_PORT), 4'd8, rand_data());
         default: send_access(CMD_READ, 8'(OFS_EEPROM), 4'd1, rand_data());
      endcase
   endtask

   task automatic run_eeprom_read();
      logic [9:0] frame;
      logic       di;
      int         cut;
      frame[9]   = 1'($urandom);
      frame[8:6] = ($urandom_range(0, 5) == 0) ? 3'($urandom) : EE_OP_READ;
      case ($urandom_range(0, 5))
         0: frame[5:0] = EE_IDX_W0;
         1: frame[5:0] = EE_IDX_W1;
         2: frame[5:0] = EE_IDX_W2;
         3: frame[5:0] = EE_IDX_W3;
         4: frame[5:0] = EE_IDX_CSUM;
         default: frame[5:0] = 6'($urandom);
      endcase
      cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 26)) : -1;
      drive_pins(pin_byte(1'b0, 1'b0, 1'b0));
      for (int s = 0; s < 27; s++) begin
         if (s == cut)
            drive_pins(pin_byte(1'b0, 1'b0, 1'b0));
         if (s < 10) begin
            di = frame[9-s];
            drive_pins(pin_byte(1'b1, 1'b0, di));
            drive_pins(pin_byte(1'b1, 1'b1, di));
         end else begin
            read_pins();
            drive_pins(pin_byte(1'b1, 1'b0, 1'($urandom)));
            drive_pins(pin_byte(1'b1, 1'b1, 1'($urandom)));
         end
      end
   endtask

   task automatic run_mdi_frame();
      logic [31:0] frame;
      frame[31:28] = 4'($urandom);
      if ($urandom_range(0, 3) == 0)
         frame[27:26] = 2'($urandom);
      else
         frame[27:26] = $urandom_range(0, 1) ? MDI_OP_READ : MDI_OP_WRITE;
      frame[25:21] = ($urandom_range(0, 3) == 0) ? 5'($urandom) : MDI_PHY_ADDR;
      frame[20:16] = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
      frame[15:0]  = 16'($urandom);
      case ($urandom_range(0, 2))
         0: send_access(CMD_WRITE, 8'(OFS_MDI), 4'd4, {$urandom, frame});
         1: send_access(CMD_WRITE, 8'(OFS_MDI), 4'd8, {$urandom, frame});
         default: send_access(CMD_WRITE, 8'(OFS_MDI - 4), 4'd8, {frame, $urandom});
      endcase
      case ($urandom_range(0, 3))
         0: send_access(CMD_READ, 8'(OFS_MDI), 4'd4, rand_data());
         1: send_access(CMD_READ, 8'(OFS_MDI), 4'd2, rand_data());
         2: send_access(CMD_READ, 8'(OFS_MDI + 2), 4'd2, rand_data());
         default: send_access(CMD_READ, 8'd0, 4'd8, rand_data());
      endcase
   endtask

   task automatic run_scb_command();
      logic [3:0] cu;
      logic [3:0] ru;
      if ($urandom_range(0, 1))
         send_access(CMD_WRITE, 8'(OFS_POINTER), 4'd4, rand_data());
      case ($urandom_range(0, 2))
         0: cu = CU_CMD_COMPLETE;
         1: cu = CU_CMD_LOAD_BASE;
         default: cu = 4'($urandom);
      endcase
      ru = $urandom_range(0, 1) ? RU_CMD_LOAD_BASE : 4'($urandom);
      case ($urandom_range(0, 2))
         0: send_access(CMD_WRITE, 8'(OFS_COMMAND), 4'd1, {$urandom, 24'($urandom), cu, ru});
         1: send_access(CMD_WRITE, 8'(OFS_COMMAND), 4'd2,
                        {$urandom, 16'($urandom), 8'($urandom), cu, ru});
         default: send_access(CMD_WRITE, 8'd0, 4'd4,
                              {$urandom, 8'($urandom), cu, ru, 16'($urandom)});
      endcase
      if ($urandom_range(0, 1))
         send_access(CMD_READ, 8'd0, 4'd4, rand_data());
   endtask

   task automatic run_port_command();
      logic [31:0] port;
      port = $urandom;
      case ($urandom_range(0, 2))
         0: send_access(CMD_WRITE, 8'(OFS_PORT), 4'd4, {$urandom, port});
         1: send_access(CMD_WRITE, 8'(OFS_POINTER), 4'd8, {port, $urandom});
         default: send_access(CMD_WRITE, 8'(OFS_PORT), 4'd8, {$urandom, port});
      endcase
   endtask

   task automatic run_noise();
      logic [7:0] ofs;
      ofs = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, WINDOW - 1));
      send_access(1'($urandom), ofs, 4'($urandom), rand_data());
   endtask

   task automatic test_window_limits();
      send_access(CMD_READ, 8'd0, 4'd8, '0);
      send_access(CMD_READ, 8'(WINDOW - 8), 4'd8, '0);
      send_access(CMD_READ, 8'(WINDOW - 7), 4'd8, '0);
      send_access(CMD_READ, 8'hff, 4'hf, '1);
      send_access(CMD_WRITE, 8'(WINDOW - 4), 4'd8, '1);
      send_access(CMD_READ, 8'd0, 4'd0, '0);
      send_access(CMD_WRITE, 8'(OFS_COMMAND + 1), 4'd0, '1);
      send_access(CMD_READ, 8'd0, 4'hf, '0);
   endtask

   task automatic test_scb_commands();
      send_access(CMD_WRITE, 8'(OFS_POINTER), 4'd4, 64'h0000_0000_1234_5678);
      send_access(CMD_WRITE, 8'(OFS_COMMAND), 4'd1, {56'd0, CU_CMD_LOAD_BASE, 4'h0});
      send_access(CMD_WRITE, 8'(OFS_COMMAND), 4'd1, {56'd0, CU_CMD_COMPLETE, RU_CMD_LOAD_BASE});
      send_access(CMD_WRITE, 8'd0, 4'd8, '1);
      send_access(CMD_WRITE, 8'(OFS_COMMAND), 4'd1, {56'd0, CU_CMD_COMPLETE, 4'h0});
      send_access(CMD_READ, 8'd0, 4'd8, '0);
   endtask

   task automatic test_mdi_frames();
      send_access(CMD_WRITE, 8'(OFS_MDI), 4'd4,
                  {32'd0, 4'h0, MDI_OP_READ, MDI_PHY_ADDR, 5'd1, 16'h0000});
      send_access(CMD_WRITE, 8'(OFS_MDI), 4'd4,
                  {32'd0, 4'h0, MDI_OP_WRITE, MDI_PHY_ADDR, PHY_CTRL_REG, 16'h8123});
      send_access(CMD_WRITE, 8'(OFS_MDI), 4'd4,
                  {32'd0, 4'hf, MDI_OP_WRITE, 5'd2, 5'd3, 16'hffff});
      send_access(CMD_WRITE, 8'(OFS_MDI), 4'd4,
                  {32'd0, 4'h0, MDI_OP_INVALID, MDI_PHY_ADDR, PHY_CTRL_REG, 16'h5555});
      send_access(CMD_READ, 8'(OFS_MDI), 4'd4, '0);
   endtask

   task automatic test_port_commands();
      send_access(CMD_WRITE, 8'(OFS_PORT), 4'd4, {32'd0, 30'h2bad_beef, PORT_DUMP});
      send_access(CMD_WRITE, 8'(OFS_PORT), 4'd4, {32'd0, 30'h3fff_ffff, PORT_NOP});
      send_access(CMD_WRITE, 8'(OFS_PORT), 4'd4, {32'd0, 30'h0, PORT_SEL_RESET});
      send_access(CMD_WRITE, 8'(OFS_PORT), 4'd4, {32'hffff_ffff, 30'h3fff_ffff, PORT_RESET});
      send_access(CMD_READ, 8'd0, 4'd8, '0);
   endtask

   task automatic test_eeprom_pins();
      send_access(CMD_WRITE, 8'(OFS_EEPROM), 4'd1, {56'd0, 8'hff});
      send_access(CMD_READ, 8'(OFS_EEPROM), 4'd2, '0);
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input logic [47:0] addr,
                                      input int items);
      int start;
      int pick;
      load_station(addr);
      idle_pct  = idle;
      stall_pct = stall;
      start     = accepted_count;
      while (accepted_count - start < items) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 5)
            run_eeprom_read();
         else if (pick < 30)
            run_mdi_frame();
         else if (pick < 50)
            run_scb_command();
         else if (pick < 53)
            run_port_command();
         else
            run_noise();
      end
   endtask

   always @(negedge clock)
      rsp_ready <= !reset && ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      rsp_item_type want;
      if (rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: result with none expected: read_data %h dma_op %0d dma_addr %h",
                     $time, rsp_item.read_data, rsp_item.dma_op, rsp_item.dma_addr);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_item.read_data !== want.read_data) begin
               $display("%0t: read_data expected %h actual %h",
                        $time, want.read_data, rsp_item.read_data);
               error_count++;
            end
            if (rsp_item.dma_op !== want.dma_op) begin
               $display("%0t: dma_op expected %0d actual %0d",
                        $time, want.dma_op, rsp_item.dma_op);
               error_count++;
            end
            if (rsp_item.dma_addr !== want.dma_addr) begin
               $display("%0t: dma_addr expected %h actual %h",
                        $time, want.dma_addr, rsp_item.dma_addr);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      station = STATION_RESET;
      foreach (phy_file[i]) phy_file[i] = PHY_RESET[i];
      clear_csr_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_window_limits();
      test_scb_commands();
      test_mdi_frames();
      test_port_commands();
      test_eeprom_pins();

      test_random_traffic(0, 0, 48'h0, 475);
      test_random_traffic(63, 0, 48'hffff_ffff_ffff, 475);
      test_random_traffic(0, 63, {16'($urandom), $urandom}, 475);
      test_random_traffic(33, 33, STATION_RESET, 475);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
